// ===== rtl/swsp_pkg.sv =====
// ----------------------------------------------------------------------------
// swsp_pkg: shared types and constants of the single-wire pulse decoder
// timing limits in microseconds, result kinds and the pulse check flags
// ----------------------------------------------------------------------------
`default_nettype none

package swsp_pkg;

    localparam int DATA_BITS = 40;
    localparam int BITS_W    = 6;
    localparam int TPU_W     = 7;
    localparam int TICKS_W   = 24;
    localparam int VALUE_W   = 16;
    localparam int BYTE_W    = 8;

    localparam logic [TPU_W-1:0] TPU_RESET = 7'd12;

    // timing limits in microseconds
    localparam int US_1MS  = 1000;
    localparam int US_10MS = 10000;
    localparam int US_20   = 20;
    localparam int US_40   = 40;
    localparam int US_50   = 50;
    localparam int US_60   = 60;
    localparam int US_70   = 70;
    localparam int US_80   = 80;
    localparam int US_90   = 90;

    typedef enum logic [2:0] {
        KIND_HOST_START = 3'd0,
        KIND_SENSOR     = 3'd1,
        KIND_HUMIDITY   = 3'd2,
        KIND_TEMP       = 3'd3,
        KIND_CHECKSUM   = 3'd4
    } frame_kind_t;

    // level-independent range flags except host_start, which includes the level
    typedef struct packed {
        logic host_start;
        logic in_20_40;
        logic in_70_90;
        logic in_40_60;
        logic bit_high_ok;
        logic bit_one;
    } pulse_chk_t;

endpackage

`default_nettype wire

// ===== rtl/swsp_pulse_check.sv =====
// ----------------------------------------------------------------------------
// swsp_pulse_check: pulse length classifier
// scales the microsecond limits by the tick rate and compares one pulse
// ----------------------------------------------------------------------------
`default_nettype none

module swsp_pulse_check (
    input  wire logic [swsp_pkg::TPU_W-1:0]   tpu,
    input  wire logic                         level,
    input  wire logic [swsp_pkg::TICKS_W-1:0] ticks,
    output swsp_pkg::pulse_chk_t              chk
);

    logic [swsp_pkg::TICKS_W-1:0] th_1ms, th_10ms;
    logic [swsp_pkg::TICKS_W-1:0] th_20, th_40, th_50, th_60, th_70, th_80, th_90;

    // constant multiplies, the largest product fits 21 bits
    assign th_1ms  = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_1MS));
    assign th_10ms = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_10MS));
    assign th_20   = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_20));
    assign th_40   = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_40));
    assign th_50   = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_50));
    assign th_60   = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_60));
    assign th_70   = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_70));
    assign th_80   = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_80));
    assign th_90   = swsp_pkg::TICKS_W'(32'(tpu) * 32'(swsp_pkg::US_90));

    always_comb begin
        chk.host_start  = !level && (ticks > th_1ms) && (ticks < th_10ms);
        chk.in_20_40    = (ticks >= th_20) && (ticks <= th_40);
        chk.in_70_90    = (ticks >= th_70) && (ticks <= th_90);
        chk.in_40_60    = (ticks >= th_40) && (ticks <= th_60);
        // high bit window with the ambiguous middle band cut out
        chk.bit_high_ok = (ticks >= th_20) && (ticks <= th_80)
                          && !((ticks > th_40) && (ticks < th_60));
        chk.bit_one     = (ticks >= th_50);
    end

endmodule

`default_nettype wire

// ===== rtl/single_wire_sensor_pulse_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// single_wire_sensor_pulse_decoder_unit: single-wire sensor pulse decoder
// turns finished line pulses into host start, sensor response and data words
// ----------------------------------------------------------------------------
// decode: an accepted pulse word enters the input register and is decoded there
//   once its results have room; its result words then come from the burst register
// throughput: one pulse word per cycle while each yields at most one result and
//   the output takes each word; the final data bit yields three result words
// reset: aresetn is synchronous, active low; it clears the phase, the bit count,
//   the shift register and all valid flags, and sets the tick rate to 12
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_sensor_pulse_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // tick rate register
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,   // ticks_per_microsecond

    // pulse words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // [23:0] pulse_ticks
    input  wire logic        s_tuser,       // [0] pulse_level

    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [2:0] frame_kind, [18:3] frame_value,
                                            // [19] checksum_bad,
                                            // [27:20] expected_checksum, [31:28] zero
    output logic             m_tlast        // last_of_run
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WAIT    = 3'd1,
        PH_SLOW    = 3'd2,
        PH_SHIGH   = 3'd3,
        PH_BITLOW  = 3'd4,
        PH_BITHIGH = 3'd5
    } phase_t;

    localparam int DB = swsp_pkg::DATA_BITS;
    localparam int VW = swsp_pkg::VALUE_W;
    localparam int BW = swsp_pkg::BYTE_W;

    // configuration
    logic [swsp_pkg::TPU_W-1:0]   tpu_reg;

    // input register
    logic                         in_valid_reg, in_valid_next;
    logic                         in_level_reg;
    logic [swsp_pkg::TICKS_W-1:0] in_ticks_reg;

    // decoder state
    phase_t                       phase_reg, phase_next;
    logic [swsp_pkg::BITS_W-1:0]  bits_reg, bits_next;
    logic [DB-1:0]                shift_reg, shift_next;

    // result burst: either one signal word or the three data words
    logic [1:0]                   cnt_reg, cnt_next;
    logic                         burst_data_reg, burst_data_next;
    swsp_pkg::frame_kind_t        burst_kind_reg, burst_kind_next;
    logic [DB-1:0]                word_reg, word_next;
    logic [BW-1:0]                sum_reg, sum_next;

    swsp_pkg::pulse_chk_t         chk;
    logic                         out_free;
    logic                         process;
    logic                         m_fire;
    logic                         s_fire;
    logic [1:0]                   n_res;
    logic [DB-1:0]                shifted;
    logic [BW-1:0]                sum_calc;
    logic                         last_bit;

    swsp_pulse_check u_check (
        .tpu   (tpu_reg),
        .level (in_level_reg),
        .ticks (in_ticks_reg),
        .chk   (chk)
    );

    // shifted word and checksum for the final bit
    assign shifted  = {shift_reg[DB-2:0], chk.bit_one};
    assign last_bit = (bits_reg == swsp_pkg::BITS_W'(DB - 1));
    assign sum_calc = BW'(10'(shifted[DB-1 -: BW]) + 10'(shifted[DB-1-BW -: BW])
                        + 10'(shifted[DB-1-2*BW -: BW]) + 10'(shifted[DB-1-3*BW -: BW]));

    // number of result words the pulse in the input register will produce
    always_comb begin
        n_res = 2'd0;
        case (phase_reg)
            PH_WAIT:    if (in_level_reg && chk.in_20_40) n_res = 2'd1;
            PH_SHIGH:   if (in_level_reg && chk.in_70_90) n_res = 2'd1;
            PH_BITHIGH: if (in_level_reg && chk.bit_high_ok && last_bit) n_res = 2'd3;
            default:    n_res = 2'd0;
        endcase
    end

    // a pulse is decoded once its results have room in the burst register
    assign m_fire   = m_tvalid && m_tready;
    assign out_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign process  = in_valid_reg && ((n_res == 2'd0) || out_free);
    assign s_tready = !in_valid_reg || process;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next   = in_valid_reg;
        phase_next      = phase_reg;
        bits_next       = bits_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        burst_data_next = burst_data_reg;
        burst_kind_next = burst_kind_reg;
        word_next       = word_reg;
        sum_next        = sum_reg;

        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end

        if (m_fire) begin
            cnt_next = cnt_reg - 2'd1;
        end

        if (process) begin
            // failure path by default: clear data, retry the pulse as host start
            phase_next = chk.host_start ? PH_WAIT : PH_IDLE;
            bits_next  = '0;
            shift_next = '0;
            case (phase_reg)
                PH_WAIT: begin
                    if (in_level_reg && chk.in_20_40) begin
                        phase_next      = PH_SLOW;
                        cnt_next        = 2'd1;
                        burst_data_next = 1'b0;
                        burst_kind_next = swsp_pkg::KIND_HOST_START;
                    end
                end
                PH_SLOW: begin
                    if (!in_level_reg && chk.in_70_90) phase_next = PH_SHIGH;
                end
                PH_SHIGH: begin
                    if (in_level_reg && chk.in_70_90) begin
                        phase_next      = PH_BITLOW;
                        cnt_next        = 2'd1;
                        burst_data_next = 1'b0;
                        burst_kind_next = swsp_pkg::KIND_SENSOR;
                    end
                end
                PH_BITLOW: begin
                    if (!in_level_reg && chk.in_40_60) begin
                        phase_next = PH_BITHIGH;
                        bits_next  = bits_reg;
                        shift_next = shift_reg;
                    end
                end
                PH_BITHIGH: begin
                    if (in_level_reg && chk.bit_high_ok) begin
                        if (last_bit) begin
                            // whole frame in: emit humidity, temperature, checksum
                            phase_next      = PH_IDLE;
                            cnt_next        = 2'd3;
                            burst_data_next = 1'b1;
                            word_next       = shifted;
                            sum_next        = sum_calc;
                        end else begin
                            phase_next = PH_BITLOW;
                            bits_next  = bits_reg + 1'b1;
                            shift_next = shifted;
                        end
                    end
                end
                default: begin
                    // idle: only a host start leaves, already set above
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg        <= swsp_pkg::TPU_RESET;
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_IDLE;
            bits_reg       <= '0;
            shift_reg      <= '0;
            cnt_reg        <= 2'd0;
            burst_data_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) tpu_reg <= cfg_wr_data;
            in_valid_reg   <= in_valid_next;
            phase_reg      <= phase_next;
            bits_reg       <= bits_next;
            shift_reg      <= shift_next;
            cnt_reg        <= cnt_next;
            burst_data_reg <= burst_data_next;
        end
        if (s_fire) begin
            in_level_reg <= s_tuser;
            in_ticks_reg <= s_tdata;
        end
        burst_kind_reg <= burst_kind_next;
        word_reg       <= word_next;
        sum_reg        <= sum_next;
    end

    // output word mux; the remaining count picks the data word
    swsp_pkg::frame_kind_t out_kind;
    logic [VW-1:0]         out_value;
    logic                  out_bad;
    logic [BW-1:0]         out_expect;

    always_comb begin
        out_kind   = burst_kind_reg;
        out_value  = '0;
        out_bad    = 1'b0;
        out_expect = '0;
        m_tlast    = 1'b1;
        if (burst_data_reg) begin
            case (cnt_reg)
                2'd3: begin
                    out_kind  = swsp_pkg::KIND_HUMIDITY;
                    out_value = word_reg[DB-1 -: VW];
                    m_tlast   = 1'b0;
                end
                2'd2: begin
                    out_kind  = swsp_pkg::KIND_TEMP;
                    out_value = word_reg[DB-1-VW -: VW];
                    m_tlast   = 1'b0;
                end
                default: begin
                    out_kind   = swsp_pkg::KIND_CHECKSUM;
                    out_value  = VW'(word_reg[BW-1:0]);
                    out_bad    = (word_reg[BW-1:0] != sum_reg);
                    out_expect = sum_reg;
                end
            endcase
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {4'd0, out_expect, out_bad, out_value, out_kind};

    // a word that is not the last of its run is always followed by another
    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && !m_tlast |=> m_tvalid)
        else $error("result burst ended early");

    // bit count never reaches the frame length while bits are being collected
    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BITLOW || phase_reg == PH_BITHIGH)
        |-> bits_reg < swsp_pkg::BITS_W'(DB))
        else $error("bit count overflow");

    // checksum flag agrees with the received and expected bytes
    a_checksum_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == swsp_pkg::KIND_CHECKSUM)
        |-> m_tdata[19] == (m_tdata[10:3] != m_tdata[27:20]))
        else $error("checksum flag mismatch");

    // a decoded pulse always frees or refills the input register
    a_in_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && (cnt_reg == 2'd0) |-> s_tready)
        else $error("decoder stalled with empty output");

endmodule

`default_nettype wire

// ===== verif/swsp_frame_checker.sv =====
// ----------------------------------------------------------------------------
// swsp_frame_checker: result word scoreboard for the single-wire pulse decoder
// decodes every accepted pulse word with its own copy of the decoder state and
// compares each accepted result word, field by field, with the oldest one owed
// ----------------------------------------------------------------------------

module swsp_frame_checker
    import swsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tlast,
    output int               frame_errors,
    output int               frames_owed,
    output int               frames_predicted,
    output int               frames_checked
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOST_WAIT,
        ST_RESP_LOW,
        ST_RESP_HIGH,
        ST_BIT_LOW,
        ST_BIT_HIGH
    } decode_state_t;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [3:0]         pad;
        logic [BYTE_W-1:0]  sum;
        logic               bad;
        logic [VALUE_W-1:0] value;
        frame_kind_t        kind;
    } frame_word_t;

    typedef struct packed {
        logic        last;
        frame_word_t word;
    } frame_t;

    frame_t               pending_frames[$];
    logic [TPU_W-1:0]     rate;
    decode_state_t        state;
    logic [BITS_W-1:0]    bit_count;
    logic [DATA_BITS-1:0] bit_shift;

    function automatic int unsigned us_ticks(input int unsigned n);
        return n * rate;
    endfunction

    function automatic logic in_band(input int unsigned t, input int unsigned lo,
                                     input int unsigned hi);
        return t >= us_ticks(lo) && t <= us_ticks(hi);
    endfunction

    function automatic logic host_start(input logic level, input int unsigned t);
        return !level && t > us_ticks(US_1MS) && t < us_ticks(US_10MS);
    endfunction

    task automatic owe(input frame_kind_t kind, input logic [VALUE_W-1:0] value,
                       input logic bad, input logic [BYTE_W-1:0] sum, input logic last);
        frame_t f;
        f.last       = last;
        f.word.pad   = '0;
        f.word.sum   = sum;
        f.word.bad   = bad;
        f.word.value = value;
        f.word.kind  = kind;
        pending_frames.push_back(f);
        frames_predicted++;
    endtask

    // a failed check drops the partial data; a low pulse gets a second look
    task automatic abandon(input logic level, input int unsigned t);
        bit_count = '0;
        bit_shift = '0;
        state     = host_start(level, t) ? ST_HOST_WAIT : ST_IDLE;
    endtask

    task automatic decode_pulse(input logic level, input logic [TICKS_W-1:0] ticks);
        int unsigned        t;
        logic [VALUE_W-1:0] hum;
        logic [VALUE_W-1:0] tmp;
        logic [BYTE_W-1:0]  rx;
        logic [BYTE_W-1:0]  sum;
        t = ticks;
        case (state)
            ST_HOST_WAIT: begin
                if (level && in_band(t, US_20, US_40)) begin
                    state = ST_RESP_LOW;
                    owe(KIND_HOST_START, '0, 1'b0, '0, 1'b1);
                end else begin
                    abandon(level, t);
                end
            end
            ST_RESP_LOW: begin
                if (!level && in_band(t, US_70, US_90))
                    state = ST_RESP_HIGH;
                else
                    abandon(level, t);
            end
            ST_RESP_HIGH: begin
                if (level && in_band(t, US_70, US_90)) begin
                    state     = ST_BIT_LOW;
                    bit_count = '0;
                    bit_shift = '0;
                    owe(KIND_SENSOR, '0, 1'b0, '0, 1'b1);
                end else begin
                    abandon(level, t);
                end
            end
            ST_BIT_LOW: begin
                if (!level && in_band(t, US_40, US_60))
                    state = ST_BIT_HIGH;
                else
                    abandon(level, t);
            end
            ST_BIT_HIGH: begin
                if (!level || !in_band(t, US_20, US_80) ||
                    (t > us_ticks(US_40) && t < us_ticks(US_60))) begin
                    abandon(level, t);
                end else begin
                    bit_shift = {bit_shift[DATA_BITS-2:0], logic'(t >= us_ticks(US_50))};
                    bit_count = bit_count + 1'b1;
                    if (bit_count < DATA_BITS) begin
                        state = ST_BIT_LOW;
                    end else begin
                        hum = bit_shift[39:24];
                        tmp = bit_shift[23:8];
                        rx  = bit_shift[7:0];
                        sum = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
                        owe(KIND_HUMIDITY, hum, 1'b0, '0, 1'b0);
                        owe(KIND_TEMP, tmp, 1'b0, '0, 1'b0);
                        owe(KIND_CHECKSUM, {8'h00, rx}, rx != sum, sum, 1'b1);
                        state     = ST_IDLE;
                        bit_count = '0;
                        bit_shift = '0;
                    end
                end
            end
            default: abandon(level, t);
        endcase
    endtask

    task automatic check_word(input logic [31:0] data, input logic last);
        frame_t      want;
        frame_word_t got;
        got = frame_word_t'(data);
        frames_checked++;
        if (pending_frames.size() == 0) begin
            if (frame_errors < 10)
                $display("result word %0d: none owed, got kind %0d value %h last %b",
                         frames_checked, got.kind, got.value, last);
            frame_errors++;
        end else begin
            want = pending_frames.pop_front();
            if (got.kind !== want.word.kind || got.value !== want.word.value ||
                got.bad !== want.word.bad || got.sum !== want.word.sum ||
                got.pad !== want.word.pad || last !== want.last) begin
                if (frame_errors < 10)
                    $display({"result word %0d (exp/got): kind %0d/%0d value %h/%h ",
                              "bad %b/%b sum %h/%h pad %h/%h last %b/%b"},
                             frames_checked, want.word.kind, got.kind,
                             want.word.value, got.value, want.word.bad, got.bad,
                             want.word.sum, got.sum, want.word.pad, got.pad,
                             want.last, last);
                frame_errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rate             = TPU_RESET;
            state            = ST_IDLE;
            bit_count        = '0;
            bit_shift        = '0;
            frame_errors     = 0;
            frames_predicted = 0;
            frames_checked   = 0;
            pending_frames.delete();
        end else begin
            if (cfg_wr_en)
                rate = cfg_wr_data;
            if (s_tvalid && s_tready)
                decode_pulse(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_word(m_tdata, m_tlast);
        end
        frames_owed = pending_frames.size();
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level of the single-wire pulse decoder regression
// drives pulse words (directed corner pulses, then well-formed, broken and
// noise sequences) at several tick rates with random gaps and output stalls;
// a checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------

module testbench;
    import swsp_pkg::*;

    localparam int MAX_GAP        = 14;
    localparam int HOLD_CYCLES    = 400;   // long output stall to back up the block
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int SETTLE_CYCLES  = 6;     // drain margin after the last owed word
    localparam int FRAME_PULSES   = 4 + 2 * DATA_BITS;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [TPU_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [TICKS_W-1:0] s_tdata     = '0;
    logic               s_tuser     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [31:0]        m_tdata;
    logic               m_tlast;

    int frame_errors;
    int frames_owed;
    int frames_predicted;
    int frames_checked;

    // stimulus side state
    logic [TPU_W-1:0] rate_now    = TPU_RESET;
    logic             sender_calm = 1'b0;  // no gaps between pulse words
    logic             hold_req    = 1'b0;  // asks the receiver for one long stall
    int               pulses_sent = 0;
    int               frames_sent = 0;
    int               rates_used  = 1;
    int               holds_done  = 0;
    int               idle_cycles = 0;

    single_wire_sensor_pulse_decoder_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    swsp_frame_checker frame_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .frame_errors     (frame_errors),
        .frames_owed      (frames_owed),
        .frames_predicted (frames_predicted),
        .frames_checked   (frames_checked)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog: any word on either channel or a register write resets the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d result words owed",
                     idle_cycles, frames_owed);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall before each word, calm stretches, one long hold-off
    initial begin
        int   stall;
        int   calm_left;
        logic calm;
        calm_left = 0;
        calm      = 1'b0;
        forever begin
            if (hold_req) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end
            if (calm_left == 0) begin
                calm_left = $urandom_range(4, 20);
                calm      = ($urandom_range(0, 2) == 0);
            end
            calm_left--;
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            // tready is left high until the next word is taken
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic int unsigned us(input int unsigned n);
        return n * rate_now;
    endfunction

    // value inside [lo, hi], biased toward both bounds
    function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // value outside [lo, hi], mostly just past a bound
    function automatic int unsigned pick_bad(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 3))
            0:       return (lo > 0) ? lo - 1 : hi + 1;
            1:       return (lo > 0) ? $urandom_range(lo - 1, 0) : hi + 1;
            2:       return pick_in(hi + 1, 2 * hi + 1);
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // humidity, temperature and checksum byte, MSB first
    function automatic logic [DATA_BITS-1:0] make_data(input logic good_sum);
        logic [VALUE_W-1:0] hum;
        logic [VALUE_W-1:0] tmp;
        logic [BYTE_W-1:0]  sum;
        hum = $urandom;
        tmp = $urandom;
        if ($urandom_range(0, 5) == 0)
            hum = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 5) == 0)
            tmp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        sum = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
        return {hum, tmp, good_sum ? sum : BYTE_W'($urandom)};
    endfunction

    // one pulse word; lengths past the field saturate
    task automatic send_pulse(input logic level, input int unsigned ticks);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= level;
        s_tdata  <= (ticks > 32'h00FF_FFFF) ? 24'hFF_FFFF : ticks[TICKS_W-1:0];
        do @(posedge aclk); while (!s_tready);
        pulses_sent++;
    endtask

    // full exchange: host start, host wait, sensor low/high, then 40 bits;
    // break_at picks a pulse to spoil and ends the exchange there
    task automatic send_frame(input logic [DATA_BITS-1:0] bits, input int break_at);
        logic        level;
        logic        bit_val;
        int unsigned lo;
        int unsigned hi;
        for (int k = 0; k < FRAME_PULSES; k++) begin
            if (k == 0) begin
                level = 1'b0;
                lo    = us(US_1MS) + 1;
                hi    = us(US_10MS) - 1;
            end else if (k == 1) begin
                level = 1'b1;
                lo    = us(US_20);
                hi    = us(US_40);
            end else if (k == 2 || k == 3) begin
                level = (k == 3);
                lo    = us(US_70);
                hi    = us(US_90);
            end else if (k % 2 == 0) begin
                level = 1'b0;
                lo    = us(US_40);
                hi    = us(US_60);
            end else begin
                level   = 1'b1;
                bit_val = bits[DATA_BITS - 1 - (k - 4) / 2];
                lo      = bit_val ? us(US_60) : us(US_20);
                hi      = bit_val ? us(US_80) : us(US_40);
            end
            if (k == break_at) begin
                case ($urandom_range(0, 3))
                    0: send_pulse(!level, pick_in(lo, hi));
                    1: send_pulse(level, pick_bad(lo, hi));
                    // a new host start in the middle of an exchange
                    2: send_pulse(1'b0, pick_in(us(US_1MS) + 1, us(US_10MS) - 1));
                    default: begin
                        // bit high in the dead band between a zero and a one
                        if (k > 4 && k % 2 == 1)
                            send_pulse(1'b1, pick_in(us(US_40) + 1, us(US_60) - 1));
                        else
                            send_pulse(level, pick_bad(lo, hi));
                    end
                endcase
                return;
            end
            send_pulse(level, pick_in(lo, hi));
        end
        frames_sent++;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:       send_pulse($urandom_range(0, 1), $urandom_range(32'h00FF_FFFF, 0));
            1:       send_pulse($urandom_range(0, 1), $urandom_range(us(100), 0));
            2:       send_pulse(1'b0, pick_in(us(US_1MS) + 1, us(US_10MS) - 1));
            default: send_pulse(1'b1, $urandom_range(us(100), 0));
        endcase
    endtask

    // mostly clean exchanges, some spoiled ones, a little line noise
    task automatic run_traffic(input int item_goal, input int word_goal);
        int item_base;
        int word_base;
        int pick;
        item_base = pulses_sent;
        word_base = frames_predicted;
        while (pulses_sent - item_base < item_goal ||
               frames_predicted - word_base < word_goal) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            pick        = $urandom_range(0, 9);
            if (pick < 6)
                send_frame(make_data($urandom_range(0, 3) != 0), -1);
            else if (pick < 9)
                send_frame(make_data(1'b1), $urandom_range(0, FRAME_PULSES - 1));
            else
                repeat ($urandom_range(1, 4)) send_noise();
        end
        sender_calm = 1'b0;
    endtask

    // stop offering, wait for every owed word, then let the pipeline drain
    task automatic settle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (frames_owed != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_rate(input logic [TPU_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk) cfg_wr_en <= 1'b0;
        rate_now = value;
        rates_used++;
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // corner pulses at the reset tick rate
        send_pulse(1'b1, 32'h00FF_FFFF);       // high while idle, all ones
        send_pulse(1'b1, 0);                   // high while idle, all zeros
        send_pulse(1'b0, 0);                   // too short for a host start
        send_pulse(1'b0, 32'h00FF_FFFF);       // saturated low, too long
        send_pulse(1'b0, us(US_1MS));          // exactly 1 ms is rejected
        send_pulse(1'b0, us(US_10MS));         // exactly 10 ms is rejected
        send_pulse(1'b0, us(US_10MS) - 1);     // longest host start
        send_pulse(1'b1, us(US_20) - 1);       // host wait just too short
        send_pulse(1'b0, us(US_1MS) + 1);      // shortest host start
        send_pulse(1'b1, us(US_20));           // host wait at lower bound
        send_pulse(1'b0, us(US_90) + 1);       // sensor low too long, not a start
        send_pulse(1'b0, us(5000));
        send_pulse(1'b0, us(2000));            // low where high expected, restarts
        send_pulse(1'b1, us(US_40));           // host wait at upper bound
        send_pulse(1'b0, us(US_70));
        send_pulse(1'b1, us(US_90));           // sensor response
        send_pulse(1'b1, us(US_50));           // high where bit low expected
        send_pulse(1'b0, us(3000));
        send_pulse(1'b1, us(30));
        send_pulse(1'b0, us(US_90));
        send_pulse(1'b1, us(US_70));
        send_pulse(1'b0, us(US_40));
        send_pulse(1'b1, us(US_50));           // bit high in the dead band
        send_pulse(1'b0, us(1500));
        send_pulse(1'b1, us(25));
        send_pulse(1'b0, us(80));
        send_pulse(1'b1, us(US_80));
        send_pulse(1'b0, us(US_60));
        send_pulse(1'b1, us(US_80));           // first data bit, a one
        send_pulse(1'b0, us(US_40) - 1);       // bit low too short

        run_traffic(60, 15);

        // slowest nonzero and fastest tick rates the register can hold
        settle();
        write_rate(7'd1);
        run_traffic(30, 10);
        settle();
        write_rate(7'd127);
        run_traffic(30, 10);

        // zero rate: nothing can ever start
        settle();
        write_rate(7'd0);
        repeat (12) send_noise();

        // back-to-back exchanges against a long output stall
        settle();
        write_rate(7'd100);
        hold_req    = 1'b1;
        sender_calm = 1'b1;
        send_frame(make_data(1'b1), -1);
        send_frame(make_data(1'b0), -1);
        sender_calm = 1'b0;
        run_traffic(20, 5);

        settle();
        write_rate($urandom_range(2, 99));
        run_traffic(40, 10);

        settle();
        $display("sent %0d pulse words, %0d complete exchanges, %0d tick rates",
                 pulses_sent, frames_sent, rates_used);
        $display("checked %0d result words with %0d mismatches, %0d long output stall",
                 frames_checked, frame_errors, holds_done);
        if (frame_errors == 0 && frames_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
